### rtl/psr_pkg.sv
// Shared types and constants for the position slew ramp generator.
package psr_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned StepW  = 31;
  localparam int unsigned IntvW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    ActRequest = 2'd0,
    ActTick    = 2'd1,
    ActAbort   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvStart = 2'd1,
    EvDone  = 2'd2
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinPos   = 2'd0,
    CfgMaxPos   = 2'd1,
    CfgSlewStep = 2'd2,
    CfgSlewIntv = 2'd3
  } cfg_idx_e;

  localparam logic signed [PosW-1:0] MinPosRst   = 32'sd0;
  localparam logic signed [PosW-1:0] MaxPosRst   = 32'sd6553600;
  localparam logic [StepW-1:0]       SlewStepRst = 31'd65536;
  localparam logic [IntvW-1:0]       SlewIntvRst = 16'd100;

endpackage

### rtl/position_slew_ramp.sv
// Slew-rate limited position ramp generator, top level.
// An accepted item moves from the input register to the result register when the latter is free.
// Throughput: one item per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when the result is not taken.
// Reset: asynchronous, active low; position, target, timer and flags clear to zero
// and the configuration registers return to their default values.
module position_slew_ramp
  import psr_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 action_i,
  input  logic signed [PosW-1:0]     target_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [PosW-1:0]     position_o,
  output logic [1:0]                 event_res_o,
  output logic                       busy_res_o
);

  localparam int unsigned ExtW = PosW + 2;

  // Configuration registers.
  logic signed [PosW-1:0] min_pos_q;
  logic signed [PosW-1:0] max_pos_q;
  logic [StepW-1:0]       slew_step_q;
  logic [IntvW-1:0]       slew_intv_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pos_q   <= MinPosRst;
      max_pos_q   <= MaxPosRst;
      slew_step_q <= SlewStepRst;
      slew_intv_q <= SlewIntvRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgMinPos:   min_pos_q   <= cfg_data_i;
        CfgMaxPos:   max_pos_q   <= cfg_data_i;
        CfgSlewStep: slew_step_q <= cfg_data_i[StepW-1:0];
        CfgSlewIntv: slew_intv_q <= cfg_data_i[IntvW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake.
  logic in_valid_q;
  logic out_valid_q;
  logic out_free;
  logic adv;

  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // Input register.
  action_e                act_q;
  logic signed [PosW-1:0] tgt_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q    <= action_e'(action_i);
      tgt_in_q <= target_i;
    end
  end

  // Ramp state.
  logic signed [PosW-1:0] cur_q, cur_d;
  logic signed [PosW-1:0] slew_tgt_q, slew_tgt_d;
  logic                   slewing_q, slewing_d;
  logic [IntvW-1:0]       intv_cnt_q, intv_cnt_d;
  logic                   pending_q, pending_d;
  event_e                 ev;

  // Clamp the requested target.
  logic signed [PosW-1:0] tgt_hi;
  logic signed [PosW-1:0] tgt_clamp;
  logic signed [ExtW-1:0] diff;
  logic [ExtW-1:0]        dist_abs;
  logic                   far;

  assign tgt_hi    = (tgt_in_q > max_pos_q) ? max_pos_q : tgt_in_q;
  assign tgt_clamp = (tgt_hi < min_pos_q) ? min_pos_q : tgt_hi;
  assign diff      = ExtW'(cur_q) - ExtW'(tgt_clamp);
  assign dist_abs  = diff[ExtW-1] ? ExtW'(-diff) : ExtW'(diff);
  assign far       = dist_abs > ExtW'(slew_step_q);

  // One step toward the target, never past it.
  logic signed [PosW-1:0] step_tgt;
  logic signed [ExtW-1:0] cur_ext;
  logic signed [ExtW-1:0] tgt_ext;
  logic signed [ExtW-1:0] step_ext;
  logic signed [ExtW-1:0] nxt_up;
  logic signed [ExtW-1:0] nxt_dn;
  logic signed [PosW-1:0] nxt_pos;

  assign step_tgt = (act_q == ActRequest) ? tgt_clamp : slew_tgt_q;
  assign cur_ext  = ExtW'(cur_q);
  assign tgt_ext  = ExtW'(step_tgt);
  assign step_ext = signed'(ExtW'(slew_step_q));
  assign nxt_up   = cur_ext + step_ext;
  assign nxt_dn   = cur_ext - step_ext;

  always_comb begin
    if (step_tgt > cur_q) begin
      nxt_pos = (nxt_up > tgt_ext) ? step_tgt : nxt_up[PosW-1:0];
    end else begin
      nxt_pos = (nxt_dn < tgt_ext) ? step_tgt : nxt_dn[PosW-1:0];
    end
  end

  logic [IntvW-1:0] intv_load;
  logic [IntvW-1:0] cnt_dec;

  assign intv_load = (slew_intv_q == '0) ? IntvW'(1) : slew_intv_q;
  assign cnt_dec   = (intv_cnt_q != '0) ? intv_cnt_q - IntvW'(1) : intv_cnt_q;

  always_comb begin
    cur_d      = cur_q;
    slew_tgt_d = slew_tgt_q;
    slewing_d  = slewing_q;
    intv_cnt_d = intv_cnt_q;
    pending_d  = pending_q;
    ev         = EvNone;
    case (act_q)
      ActRequest: begin
        if (!slewing_q) begin
          if (far) begin
            slewing_d  = 1'b1;
            slew_tgt_d = tgt_clamp;
            cur_d      = nxt_pos;
            intv_cnt_d = intv_load;
            pending_d  = 1'b1;
            ev         = EvStart;
          end else begin
            cur_d = tgt_clamp;
            ev    = EvDone;
          end
        end
      end
      ActTick: begin
        if (pending_q) begin
          intv_cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            pending_d = 1'b0;
            if (slewing_q) begin
              cur_d = nxt_pos;
              if (nxt_pos == slew_tgt_q) begin
                slewing_d = 1'b0;
                ev        = EvDone;
              end else begin
                intv_cnt_d = intv_load;
                pending_d  = 1'b1;
              end
            end else begin
              ev = EvDone;
            end
          end
        end
      end
      ActAbort: begin
        slewing_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= '0;
      slew_tgt_q <= '0;
      slewing_q  <= 1'b0;
      intv_cnt_q <= '0;
      pending_q  <= 1'b0;
    end else if (adv) begin
      cur_q      <= cur_d;
      slew_tgt_q <= slew_tgt_d;
      slewing_q  <= slewing_d;
      intv_cnt_q <= intv_cnt_d;
      pending_q  <= pending_d;
    end
  end

  // Result register.
  logic signed [PosW-1:0] pos_out_q;
  logic [1:0]             ev_out_q;
  logic                   busy_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_out_q  <= cur_d;
      ev_out_q   <= ev;
      busy_out_q <= slewing_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = pos_out_q;
  assign event_res_o = ev_out_q;
  assign busy_res_o  = busy_out_q;

endmodule

### rtl/psr_checker.sv
// Port-level checker for the position slew ramp generator, bound to the top level.
module psr_checker
  import psr_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic signed [PosW-1:0] position_o,
  input logic [1:0]             event_res_o,
  input logic                   busy_res_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(position_o)
      && $stable(event_res_o) && $stable(busy_res_o))
    else $error("stalled result changed");

  // No item reports an undefined event code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_res_o == EvNone || event_res_o == EvStart
      || event_res_o == EvDone))
    else $error("undefined event code");

  // A started slew is always busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EvStart |-> busy_res_o)
    else $error("slew started without busy");

  // Completion leaves the block idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EvDone |-> !busy_res_o)
    else $error("slew complete while busy");

endmodule

bind position_slew_ramp psr_checker u_psr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .position_o  (position_o),
  .event_res_o (event_res_o),
  .busy_res_o  (busy_res_o)
);

### dv/position_slew_ramp_tb.sv
// Self-checking testbench for the position slew ramp generator with a built-in predictor.
module position_slew_ramp_tb;
  import psr_pkg::*;

  localparam longint One = 65536;
  localparam int CycleLimit = 400000;
  localparam logic [1:0] ActUnused = 2'd3;

  typedef struct packed {
    logic [1:0]            action;
    logic signed [PosW-1:0] target;
  } ramp_cmd_t;

  typedef struct packed {
    logic signed [PosW-1:0] position;
    event_e                 ev;
    logic                   busy;
  } ramp_res_t;

  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgMinPos;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          action_i = ActTick;
  logic signed [PosW-1:0] target_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic signed [PosW-1:0] position_o;
  logic [1:0]          event_res_o;
  logic                busy_res_o;

  ramp_cmd_t ramp_cmds[$];
  ramp_res_t ramp_results_q[$];
  int        n_queued = 0;
  int        n_accepted = 0;
  int        mismatches = 0;
  int        cycles = 0;
  int        in_gap = 0;
  int        out_gap = 0;
  int        in_idle_pct = 0;
  int        out_idle_pct = 0;
  bit        calm = 1'b0;
  bit        in_took = 1'b0;

  longint      cur_pos, goal_pos, lo_lim, hi_lim, step_size;
  logic [15:0] intv_cfg, ticks_left;
  bit          slewing, timer_on;

  position_slew_ramp DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .target_i    (target_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .position_o  (position_o),
    .event_res_o (event_res_o),
    .busy_res_o  (busy_res_o)
  );

  always #5 clk = ~clk;

  function automatic event_e step_toward();
    longint nxt;
    if (goal_pos > cur_pos) begin
      nxt = cur_pos + step_size;
      if (nxt > goal_pos) nxt = goal_pos;
    end else begin
      nxt = cur_pos - step_size;
      if (nxt < goal_pos) nxt = goal_pos;
    end
    cur_pos = nxt;
    if (nxt == goal_pos) begin
      slewing = 1'b0;
      return EvDone;
    end
    ticks_left = (intv_cfg == 16'd0) ? 16'd1 : intv_cfg;
    timer_on = 1'b1;
    return EvNone;
  endfunction

  function automatic ramp_res_t predict_ramp(logic [1:0] act, logic signed [PosW-1:0] tgt);
    ramp_res_t r;
    longint    t, diff;
    event_e    ev;
    ev = EvNone;
    case (act)
      ActRequest: begin
        if (!slewing) begin
          t = longint'(tgt);
          if (t > hi_lim) t = hi_lim;
          if (t < lo_lim) t = lo_lim;
          diff = cur_pos - t;
          if (diff < 0) diff = -diff;
          if (diff > step_size) begin
            slewing = 1'b1;
            goal_pos = t;
            ev = EvStart;
            void'(step_toward());
          end else begin
            cur_pos = t;
            ev = EvDone;
          end
        end
      end
      ActTick: begin
        if (timer_on) begin
          if (ticks_left != 16'd0) ticks_left--;
          if (ticks_left == 16'd0) begin
            timer_on = 1'b0;
            ev = slewing ? step_toward() : EvDone;
          end
        end
      end
      ActAbort: slewing = 1'b0;
      default: ;
    endcase
    r.position = cur_pos[PosW-1:0];
    r.ev = ev;
    r.busy = slewing;
    return r;
  endfunction

  function automatic logic signed [PosW-1:0] pick_pos(longint lo, longint hi);
    longint unsigned span, off;
    span = longint'(hi - lo);
    off = {$urandom, $urandom} % (span + 1);
    return PosW'(lo + longint'(off));
  endfunction

  task automatic add_cmd(logic [1:0] a, logic signed [PosW-1:0] t);
    ramp_cmds.push_back('{action: a, target: t});
    n_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (n_accepted != n_queued || ramp_results_q.size() != 0);
  endtask

  task automatic write_cfg(logic signed [31:0] mn, logic signed [31:0] mx,
                           logic [StepW-1:0] stp, logic [IntvW-1:0] iv);
    cfg_idx_e    order [4] = '{CfgMinPos, CfgMaxPos, CfgSlewStep, CfgSlewIntv};
    logic [31:0] vals [4];
    vals[0] = mn;
    vals[1] = mx;
    vals[2] = {1'($urandom), stp};
    vals[3] = {16'($urandom), iv};
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index_i <= order[i];
      cfg_data_i <= vals[i];
      do @(posedge clk); while (!cfg_ready_o);
      case (order[i])
        CfgMinPos:   lo_lim = longint'($signed(vals[i]));
        CfgMaxPos:   hi_lim = longint'($signed(vals[i]));
        CfgSlewStep: step_size = longint'(vals[i][StepW-1:0]);
        CfgSlewIntv: intv_cfg = vals[i][IntvW-1:0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int n_items, bit extreme);
    logic signed [31:0] mn, mx;
    logic [StepW-1:0]   stp;
    logic [IntvW-1:0]   iv;
    longint             lo, hi;
    int                 made, k, cut;
    if (extreme) begin
      mn = 32'sh8000_0000;
      mx = 32'sh7FFF_FFFF;
      stp = '1;
      iv = '1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          mn = -32'($urandom_range(0, 8 * One));
          mx = 32'($urandom_range(0, 8 * One));
          stp = StepW'($urandom_range(One / 8, 3 * One));
          iv = IntvW'($urandom_range(0, 3));
        end
        1: begin
          mn = 32'($urandom_range(0, 4 * One));
          mx = -32'($urandom_range(One, 4 * One));
          stp = StepW'($urandom_range(One / 4, 2 * One));
          iv = IntvW'($urandom_range(0, 3));
        end
        2: begin
          mn = $urandom;
          mx = $urandom;
          stp = StepW'($urandom);
          iv = IntvW'($urandom_range(0, 2));
        end
        default: begin
          mn = -32'($urandom_range(0, 256));
          mx = 32'($urandom_range(0, 256));
          stp = StepW'($urandom_range(1, 3));
          iv = IntvW'($urandom_range(0, 2));
        end
      endcase
    end
    in_idle_pct = 15 * $urandom_range(0, 2);
    out_idle_pct = 15 * $urandom_range(0, 2);
    write_cfg(mn, mx, stp, iv);
    lo = ((mn < mx) ? longint'(mn) : longint'(mx)) - One;
    hi = ((mn < mx) ? longint'(mx) : longint'(mn)) + One;
    if (lo < -longint'(2147483648)) lo = -longint'(2147483648);
    if (hi > longint'(2147483647)) hi = longint'(2147483647);
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 3) != 0) begin
        add_cmd(ActRequest, ($urandom_range(0, 7) == 0) ? 32'($urandom) : pick_pos(lo, hi));
        k = $urandom_range(1, 40);
        cut = ($urandom_range(0, 2) == 0) ? $urandom_range(1, k) : 0;
        for (int j = 1; j <= k; j++) begin
          if (j == cut) add_cmd(ActAbort, 32'($urandom));
          else if ($urandom_range(0, 11) == 0) add_cmd(ActRequest, pick_pos(lo, hi));
          else add_cmd(ActTick, 32'($urandom));
        end
        made += k + 1;
      end else begin
        add_cmd(2'($urandom), 32'($urandom));
        made++;
      end
    end
    wait_idle();
  endtask

  always @(negedge clk) begin : drive_items
    logic                   nv;
    logic [1:0]             na;
    logic signed [PosW-1:0] nt;
    ramp_cmd_t              cmd;
    nv = in_valid_i;
    na = action_i;
    nt = target_i;
    if (!(in_valid_i && !in_took)) begin
      nv = 1'b0;
      if (in_gap != 0) begin
        in_gap--;
      end else if (ramp_cmds.size() != 0) begin
        if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(0, 6);
        end else begin
          cmd = ramp_cmds.pop_front();
          nv = 1'b1;
          na = cmd.action;
          nt = cmd.target;
        end
      end
    end
    in_valid_i <= nv;
    action_i <= na;
    target_i <= nt;
  end

  always @(negedge clk) begin : drive_ready
    if (out_gap != 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
      out_gap = $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_results
    ramp_res_t want;
    if (out_valid_o && out_ready_i) begin
      if (ramp_results_q.size() == 0) begin
        $error("unexpected result: position %0d, event_res %0d, busy_res %0d",
               position_o, event_res_o, busy_res_o);
        mismatches++;
      end else begin
        want = ramp_results_q.pop_front();
        if (position_o !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, position_o);
          mismatches++;
        end
        if (event_res_o !== want.ev) begin
          $error("event_res: expected %0d, got %0d", want.ev, event_res_o);
          mismatches++;
        end
        if (busy_res_o !== want.busy) begin
          $error("busy_res: expected %0d, got %0d", want.busy, busy_res_o);
          mismatches++;
        end
      end
    end
    in_took = in_valid_i && in_ready_o;
    if (in_took) begin
      ramp_results_q.push_back(predict_ramp(action_i, target_i));
      n_accepted++;
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    lo_lim = longint'(MinPosRst);
    hi_lim = longint'(MaxPosRst);
    step_size = longint'(SlewStepRst);
    intv_cfg = SlewIntvRst;
    cur_pos = 0;
    goal_pos = 0;
    slewing = 1'b0;
    ticks_left = '0;
    timer_on = 1'b0;
    repeat (2) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // Interval of two ticks: timer restarts, aborts and clamping at both ends.
    in_idle_pct = 30;
    out_idle_pct = 30;
    write_cfg(-32'sd655360, 32'sd655360, StepW'(One), 16'd2);
    add_cmd(ActTick, 32'sd0);
    add_cmd(ActRequest, 32'sh7FFF_FFFF);
    add_cmd(ActRequest, 32'sd0);
    add_cmd(ActUnused, 32'sh5555_5555);
    add_cmd(ActTick, 32'shAAAA_AAAA);
    add_cmd(ActTick, 32'sd0);
    add_cmd(ActAbort, 32'sd0);
    add_cmd(ActTick, 32'sd0);
    add_cmd(ActTick, 32'sd0);
    add_cmd(ActRequest, 32'sh8000_0000);
    add_cmd(ActTick, 32'sd0);
    add_cmd(ActAbort, 32'sd0);
    add_cmd(ActRequest, 32'sd98304);
    add_cmd(ActTick, 32'sd0);
    add_cmd(ActRequest, 32'sd262144);
    add_cmd(ActTick, 32'sd0);
    add_cmd(ActAbort, 32'sd0);
    add_cmd(ActRequest, 32'sd327680);
    repeat (4) add_cmd(ActTick, 32'sd0);
    wait_idle();

    // Inverted limits, zero step and zero interval: the slew never moves.
    write_cfg(32'sd196608, -32'sd196608, '0, 16'd0);
    add_cmd(ActRequest, 32'sd0);
    add_cmd(ActTick, 32'sd0);
    add_cmd(ActTick, 32'sd0);
    add_cmd(ActAbort, 32'sd0);
    add_cmd(ActTick, 32'sd0);
    add_cmd(ActTick, 32'sd0);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      if (p == 6) calm = 1'b1;
      random_phase(190, p == 3);
    end

    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
rtl/psr_pkg.sv
rtl/position_slew_ramp.sv
rtl/psr_checker.sv
dv/position_slew_ramp_tb.sv
